/* src/histogram_equalization_core_macros.svh */
// Assertion macros for the histogram equalization core.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef HISTOGRAM_EQUALIZATION_CORE_MACROS_SVH
`define HISTOGRAM_EQUALIZATION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define HE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define HE_ASSERT(lbl, prop, msg)
`define HE_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

/* src/he_pkg.sv */
package he_pkg;

  localparam int unsigned MAX_PIXELS_LOG2 = 24;
  localparam int unsigned PIXEL_BITS      = 8;
  localparam int unsigned PIX_W           = 8;

  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_MAP   = 1'b1;

  // Status from the divider back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

/* src/he_ram.sv */
module he_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/he_div.sv */
module he_div #(
  parameter int unsigned CntW  = 25,
  parameter int unsigned QuotW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [CntW-1:0]      cdf_i,
  input  logic [CntW-1:0]      total_i,
  output he_pkg::div_rsp_t     rsp_o,
  output logic [QuotW-1:0]     quotient_o
);
  import he_pkg::*;

  localparam int unsigned NumW = CntW + QuotW + 1;
  localparam int unsigned CntrW = $clog2(QuotW + 1);

  typedef enum logic {
    D_IDLE,
    D_RUN
  } div_state_e;

  div_state_e       state_q;
  logic [NumW-1:0]  rem_q;
  logic [NumW-1:0]  dsr_q;
  logic [QuotW-1:0] quot_q;
  logic [CntrW-1:0] step_q;
  logic             done_q;

  logic [NumW-1:0]  numer;
  logic             fits;

  // Numerator 2*cdf*L + total with L = 2^QuotW - 1, formed by shifts.
  assign numer = NumW'({cdf_i, {(QuotW + 1){1'b0}}}) - NumW'({cdf_i, 1'b0})
               + NumW'(total_i);
  assign fits  = rem_q >= dsr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      rem_q   <= '0;
      dsr_q   <= '0;
      quot_q  <= '0;
      step_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            rem_q   <= numer;
            // Divisor is 2*total, aligned to the top quotient bit.
            dsr_q   <= NumW'({total_i, {QuotW{1'b0}}});
            quot_q  <= '0;
            step_q  <= CntrW'(QuotW);
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          if (fits) begin
            rem_q <= rem_q - dsr_q;
          end
          quot_q <= QuotW'({quot_q, fits});
          dsr_q  <= dsr_q >> 1;
          step_q <= step_q - CntrW'(1);
          if (step_q == CntrW'(1)) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign rsp_o.busy = (state_q != D_IDLE);
  assign rsp_o.done = done_q;
  assign quotient_o = quot_q;

endmodule

/* src/histogram_equalization_core.sv */
// Channel  Direction  Handshake          Fields
// command  in         start, busy        cmd_i, pixel_value_i, last_pixel_i
// result   out        valid_o (strobe)   mapped_pixel_o, frame_end_o, no_table_o
//
// busy stays high while a count word is counted and while a map word is looked up.
// A map word's result strobe is set from S_MAP and rises as the core leaves S_MAP.
// A count word with last_pixel set also builds the table, in which the bit-serial
// divider runs once per bin.
// After reset the histogram memory is swept to zero with busy high.
// The receiver cannot stall; each result is shown for one cycle.
`include "histogram_equalization_core_macros.svh"

module histogram_equalization_core #(
  parameter int unsigned MaxPixelsLog2 = he_pkg::MAX_PIXELS_LOG2,
  parameter int unsigned PixelBits     = he_pkg::PIXEL_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cmd_i,
  input  logic [he_pkg::PIX_W-1:0] pixel_value_i,
  input  logic                     last_pixel_i,
  output logic                     valid_o,
  output logic [he_pkg::PIX_W-1:0] mapped_pixel_o,
  output logic                     frame_end_o,
  output logic                     no_table_o
);
  import he_pkg::*;

  localparam int unsigned CntW    = MaxPixelsLog2 + 1;
  localparam int unsigned NumBins = 1 << PixelBits;
  localparam int unsigned MapW    = (PixelBits < PIX_W) ? PixelBits : PIX_W;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_CNT,
    S_MAP,
    S_BRD,
    S_ACC,
    S_GO,
    S_DIV
  } state_e;

  state_e               state_q;
  logic [PixelBits-1:0] idx_q;
  logic [PixelBits-1:0] pix_q;
  logic                 last_q;
  logic [CntW-1:0]      total_q;
  logic [CntW-1:0]      cdf_q;
  logic                 map_ready_q;
  logic                 valid_q;
  logic [PIX_W-1:0]     mapped_q;
  logic                 frame_end_q;
  logic                 no_table_q;

  logic                       accept;
  logic                       at_limit;
  logic [PixelBits+PIX_W-1:0] pix_ext;
  logic [PixelBits-1:0]       pix_idx;

  logic                 h_we;
  logic [PixelBits-1:0] h_waddr;
  logic [CntW-1:0]      h_wdata;
  logic [PixelBits-1:0] h_raddr;
  logic [CntW-1:0]      h_rdata;

  logic                 m_we;
  logic [MapW-1:0]      m_rdata;
  logic [MapW+PIX_W-1:0] map_ext;

  logic                 div_start;
  div_rsp_t             div_rsp;
  logic [PixelBits-1:0] quot;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  // The total never exceeds the limit, so its top bit alone marks it.
  assign at_limit = total_q[CntW-1];
  assign pix_ext  = {{PixelBits{1'b0}}, pixel_value_i};
  assign pix_idx  = pix_ext[PixelBits-1:0];

  always_comb begin
    h_we    = 1'b0;
    h_waddr = idx_q;
    h_wdata = '0;
    h_raddr = idx_q;
    case (state_q)
      S_IDLE: h_raddr = pix_idx;
      S_CNT: begin
        h_we    = !at_limit;
        h_waddr = pix_q;
        h_wdata = h_rdata + CntW'(1);
      end
      S_CLR:   h_we = 1'b1;
      // Each bin is cleared as soon as it has been added into the running sum.
      S_ACC:   h_we = 1'b1;
      S_DIV:   h_raddr = idx_q + PixelBits'(1);
      default: h_we = 1'b0;
    endcase
  end

  he_ram #(
    .Width(CntW),
    .Depth(NumBins)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(h_waddr),
    .wdata_i(h_wdata),
    .raddr_i(h_raddr),
    .rdata_o(h_rdata)
  );

  assign m_we = (state_q == S_DIV) && div_rsp.done;

  he_ram #(
    .Width(MapW),
    .Depth(NumBins)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .waddr_i(idx_q),
    .wdata_i(quot[MapW-1:0]),
    .raddr_i(pix_idx),
    .rdata_o(m_rdata)
  );

  assign map_ext   = {{PIX_W{1'b0}}, m_rdata};
  assign div_start = (state_q == S_GO);

  he_div #(
    .CntW (CntW),
    .QuotW(PixelBits)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .cdf_i     (cdf_q),
    .total_i   (total_q),
    .rsp_o     (div_rsp),
    .quotient_o(quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      idx_q       <= '0;
      pix_q       <= '0;
      last_q      <= 1'b0;
      total_q     <= '0;
      cdf_q       <= '0;
      map_ready_q <= 1'b0;
      valid_q     <= 1'b0;
      mapped_q    <= '0;
      frame_end_q <= 1'b0;
      no_table_q  <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          idx_q <= idx_q + PixelBits'(1);
          if (idx_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            pix_q   <= pix_idx;
            last_q  <= last_pixel_i;
            state_q <= (cmd_i == CMD_MAP) ? S_MAP : S_CNT;
          end
        end
        S_CNT: begin
          if (!at_limit) begin
            total_q <= total_q + CntW'(1);
          end
          if (last_q) begin
            idx_q   <= '0;
            cdf_q   <= '0;
            state_q <= S_BRD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_MAP: begin
          valid_q     <= 1'b1;
          mapped_q    <= map_ready_q ? map_ext[PIX_W-1:0] : '0;
          no_table_q  <= !map_ready_q;
          frame_end_q <= last_q;
          state_q     <= S_IDLE;
        end
        S_BRD: state_q <= S_ACC;
        S_ACC: begin
          cdf_q   <= cdf_q + h_rdata;
          state_q <= S_GO;
        end
        S_GO: state_q <= S_DIV;
        S_DIV: begin
          if (div_rsp.done) begin
            idx_q <= idx_q + PixelBits'(1);
            if (idx_q == '1) begin
              map_ready_q <= 1'b1;
              total_q     <= '0;
              state_q     <= S_IDLE;
            end else begin
              state_q <= S_ACC;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign valid_o        = valid_q;
  assign mapped_pixel_o = mapped_q;
  assign frame_end_o    = frame_end_q;
  assign no_table_o     = no_table_q;

  `HE_ASSERT(a_strobe_single, valid_o |=> !valid_o, "result strobe held longer than one cycle")
  `HE_ASSERT(a_map_result, (accept && cmd_i == CMD_MAP) |-> ##2 valid_o, "map word gave no result")
  `HE_ASSERT(a_count_silent, (accept && cmd_i == CMD_COUNT) |-> ##2 !valid_o, "count word gave a result")
  `HE_ASSERT_IMPL(a_no_table_zero, valid_o && no_table_o, mapped_pixel_o == '0, "mapped level without a table")
  `HE_ASSERT_IMPL(a_div_free, div_start, !div_rsp.busy, "divider started while busy")

endmodule

/* sim/histogram_equalization_core_tb.sv */
`timescale 1ns / 100ps

module histogram_equalization_core_tb;
  import he_pkg::*;

  localparam int unsigned NumLevels  = 1 << PIXEL_BITS;
  localparam int unsigned CycleLimit = 4_000_000;
  // Longer than one table build, so a stray strobe after the last word is still seen.
  localparam int unsigned DrainCycles = 3000;

  typedef struct packed {
    logic [PIX_W-1:0] mapped;
    logic             frame_end;
    logic             no_table;
  } map_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             cmd_i;
  logic [PIX_W-1:0] pixel_value_i;
  logic             last_pixel_i;
  logic             valid_o;
  logic [PIX_W-1:0] mapped_pixel_o;
  logic             frame_end_o;
  logic             no_table_o;

  // Shadow of the block's state.
  bit [24:0]        hist_bins [NumLevels];
  bit [24:0]        frame_count;
  bit [PIX_W-1:0]   eq_levels [NumLevels];
  bit               eq_ready;

  map_result_t      pending_maps [$];
  int unsigned      error_count;
  int unsigned      cycle_count;
  int unsigned      idle_pct;

  histogram_equalization_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .pixel_value_i  (pixel_value_i),
    .last_pixel_i   (last_pixel_i),
    .valid_o        (valid_o),
    .mapped_pixel_o (mapped_pixel_o),
    .frame_end_o    (frame_end_o),
    .no_table_o     (no_table_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("histogram_equalization_core_tb: errors");
      $finish;
    end
  end

  // Cumulative histogram scaled to the top level, rounded half up, then a fresh histogram.
  task automatic build_level_map();
    longint unsigned cdf;
    longint unsigned total;
    cdf   = 0;
    total = frame_count;
    if (total != 0) begin
      for (int v = 0; v < NumLevels; v++) begin
        cdf += hist_bins[v];
        eq_levels[v] = PIX_W'(((2 * cdf * (NumLevels - 1)) + total) / (2 * total));
      end
      eq_ready = 1'b1;
    end
    for (int v = 0; v < NumLevels; v++) hist_bins[v] = '0;
    frame_count = '0;
  endtask

  task automatic predict_word(input logic cmd, input logic [PIX_W-1:0] pix, input logic last);
    map_result_t res;
    bit [24:0]   count_cap;
    count_cap = 25'(1) << MAX_PIXELS_LOG2;
    if (cmd == CMD_COUNT) begin
      if (frame_count < count_cap) begin
        hist_bins[pix] += 1;
        frame_count    += 1;
      end
      if (last) build_level_map();
    end else begin
      res.mapped    = eq_ready ? eq_levels[pix] : '0;
      res.frame_end = last;
      res.no_table  = !eq_ready;
      pending_maps.push_back(res);
    end
  endtask

  // Start stays high after a word is taken; it only drops for an idle gap or at the end.
  task automatic send_word(input logic cmd, input logic [PIX_W-1:0] pix, input logic last);
    int unsigned gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    cmd_i         <= cmd;
    pixel_value_i <= pix;
    last_pixel_i  <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_word(cmd, pix, last);
  endtask

  always @(posedge clk_i) begin : check_results
    map_result_t want;
    if (rst_ni && valid_o) begin
      if (pending_maps.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: mapped %0d frame_end %0b no_table %0b",
                 $time, mapped_pixel_o, frame_end_o, no_table_o);
      end else begin
        want = pending_maps.pop_front();
        if (mapped_pixel_o !== want.mapped) begin
          error_count++;
          $display("%0t: mapped_pixel expected %0d actual %0d",
                   $time, want.mapped, mapped_pixel_o);
        end
        if (frame_end_o !== want.frame_end) begin
          error_count++;
          $display("%0t: frame_end expected %0b actual %0b",
                   $time, want.frame_end, frame_end_o);
        end
        if (no_table_o !== want.no_table) begin
          error_count++;
          $display("%0t: no_table expected %0b actual %0b",
                   $time, want.no_table, no_table_o);
        end
      end
    end
  end

  task automatic test_map_without_table();
    send_word(CMD_MAP, 8'd0, 1'b0);
    send_word(CMD_MAP, 8'd255, 1'b1);
    send_word(CMD_MAP, 8'd170, 1'b0);
  endtask

  task automatic test_small_frames();
    // Three pixels at both ends of the range.
    send_word(CMD_COUNT, 8'd0, 1'b0);
    send_word(CMD_COUNT, 8'd255, 1'b0);
    send_word(CMD_COUNT, 8'd255, 1'b1);
    send_word(CMD_MAP, 8'd0, 1'b0);
    send_word(CMD_MAP, 8'd128, 1'b0);
    send_word(CMD_MAP, 8'd255, 1'b1);
    // A frame of one pixel gives a step from the lowest to the highest level.
    send_word(CMD_COUNT, 8'd128, 1'b1);
    send_word(CMD_MAP, 8'd127, 1'b0);
    send_word(CMD_MAP, 8'd128, 1'b0);
    // Two pixels put an exact half at level 0.
    send_word(CMD_COUNT, 8'd0, 1'b0);
    send_word(CMD_COUNT, 8'd255, 1'b1);
    send_word(CMD_MAP, 8'd0, 1'b0);
    // A map word with last set in the middle of a frame must not build.
    send_word(CMD_COUNT, 8'd10, 1'b0);
    send_word(CMD_MAP, 8'd10, 1'b1);
    send_word(CMD_MAP, 8'd200, 1'b0);
    send_word(CMD_COUNT, 8'd20, 1'b1);
    send_word(CMD_MAP, 8'd15, 1'b0);
    send_word(CMD_MAP, 8'd20, 1'b0);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input int unsigned shape,
                                                  input logic [PIX_W-1:0] base);
    case (shape)
      0: pick_pixel = PIX_W'($urandom_range(255));
      1: pick_pixel = base + PIX_W'($urandom_range(15));
      default: pick_pixel = $urandom_range(1) ? base : ~base;
    endcase
  endfunction

  task automatic test_random_traffic(input int unsigned n_words, input int unsigned pct);
    int unsigned      sent;
    int unsigned      frame_len;
    int unsigned      n_maps;
    int unsigned      shape;
    logic [PIX_W-1:0] base;
    idle_pct = pct;
    sent     = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 80) begin
        frame_len = ($urandom_range(19) == 0) ? $urandom_range(64, 128) : $urandom_range(1, 24);
        shape     = $urandom_range(2);
        base      = PIX_W'($urandom_range(255));
        for (int i = 0; i < frame_len; i++) begin
          // Now and then an early map word reads the previous table.
          if ($urandom_range(9) == 0) begin
            send_word(CMD_MAP, PIX_W'($urandom_range(255)), 1'($urandom_range(1)));
            sent++;
          end
          send_word(CMD_COUNT, pick_pixel(shape, base), i == frame_len - 1);
          sent++;
        end
        n_maps = $urandom_range(1, 16);
        for (int i = 0; i < n_maps; i++) begin
          send_word(CMD_MAP, PIX_W'($urandom_range(255)), $urandom_range(7) == 0);
          sent++;
        end
      end else begin
        send_word(1'($urandom_range(1)), PIX_W'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    cmd_i         <= CMD_COUNT;
    pixel_value_i <= '0;
    last_pixel_i  <= 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    idle_pct      = 0;
    frame_count   = '0;
    eq_ready      = 1'b0;
    for (int v = 0; v < NumLevels; v++) begin
      hist_bins[v] = '0;
      eq_levels[v] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_map_without_table();
    test_small_frames();
    test_random_traffic(190, 0);
    test_random_traffic(190, 62);
    test_random_traffic(190, 10);

    start <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("histogram_equalization_core_tb: clean");
    end else begin
      $display("histogram_equalization_core_tb: errors");
    end
    $finish;
  end

endmodule
